// ===== sv/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, constants and helper functions for the seven-segment scan
// multiplexer: segment tables, reciprocal constants and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

    // widths of the transaction fields
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned SEG_W    = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned SCAN_W   = 3;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 40;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE = 1'b1;

    localparam logic [TICK_W-1:0] SCAN_PERIOD_RST = 16'd3;
    localparam logic [TICK_W-1:0] TICK_MAX        = 16'hFFFF;

    // anode and blank codes
    localparam logic [SEG_W-1:0] MASK_COLON  = 8'b01111111;
    localparam logic [SEG_W-1:0] MASK_OFF    = 8'b11111111;
    localparam logic [SEG_W-1:0] BLANK_ANODE = 8'hFF;
    localparam logic [SEG_W-1:0] BLANK_CATH  = 8'h00;

    // fixed-point reciprocals, floor(v / d) == (v * recip) >> RECIP_SHIFT
    // for every 14-bit v
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned RECIP_W     = 29;
    localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1     = 29'd268435456;
    localparam logic [RECIP_W-1:0] RECIP_10    = 29'd26843546;
    localparam logic [RECIP_W-1:0] RECIP_100   = 29'd2684355;
    localparam logic [RECIP_W-1:0] RECIP_1000  = 29'd268436;
    localparam logic [RECIP_W-1:0] RECIP_10000 = 29'd26844;

    // decimal position of the digit shown
    typedef enum logic [1:0] {
        LVL_UNITS,
        LVL_TENS,
        LVL_HUNDREDS,
        LVL_THOUSANDS
    } t_level;

    typedef logic [SEG_W-1:0] t_seg_table [10];

    localparam t_seg_table ANODE_CODES = '{
        8'h88, 8'hBB, 8'h94, 8'h91, 8'hA3, 8'hC1, 8'hC0, 8'h9B, 8'h80, 8'h81
    };
    localparam t_seg_table CATHODE_CODES = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // reciprocal of the place weight
    function automatic logic [RECIP_W-1:0] low_recip(input t_level lvl);
        logic [RECIP_W-1:0] r;
        unique case (lvl)
            LVL_UNITS:     r = RECIP_1;
            LVL_TENS:      r = RECIP_10;
            LVL_HUNDREDS:  r = RECIP_100;
            LVL_THOUSANDS: r = RECIP_1000;
            default:       r = RECIP_1;
        endcase
        return r;
    endfunction

    // reciprocal of ten times the place weight
    function automatic logic [RECIP_W-1:0] high_recip(input t_level lvl);
        logic [RECIP_W-1:0] r;
        unique case (lvl)
            LVL_UNITS:     r = RECIP_10;
            LVL_TENS:      r = RECIP_100;
            LVL_HUNDREDS:  r = RECIP_1000;
            LVL_THOUSANDS: r = RECIP_10000;
            default:       r = RECIP_10;
        endcase
        return r;
    endfunction

    // segment code of a decimal digit, digits above nine wrap
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit,
                                                  input logic           anode);
        logic [DIGIT_W-1:0] d;
        d = (digit > 4'd9) ? 4'(digit - 4'd10) : digit;
        return anode ? ANODE_CODES[d] : CATHODE_CODES[d];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssm_digit_lane.sv =====
// ----------------------------------------------------------------------------
// ssm_digit_lane
// Extracts one decimal digit of a 14-bit value by reciprocal multiplication
// and maps it to a seven-segment code.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_digit_lane
    import ssm_pkg::*;
(
    input  wire logic [YEAR_W-1:0] i_value,
    input  wire t_level            i_level,
    input  wire logic              i_common_anode,
    output logic [SEG_W-1:0]       o_segments
);

    logic [PROD_W-1:0] prod_lo;
    logic [PROD_W-1:0] prod_hi;
    logic [YEAR_W-1:0] quot_lo;
    logic [YEAR_W-1:0] quot_hi;
    logic [YEAR_W-1:0] quot_hi_x10;
    logic [YEAR_W-1:0] rem;

    // two independent quotients: by the place weight and by ten times it
    always_comb begin
        prod_lo = PROD_W'(i_value) * PROD_W'(low_recip(i_level));
        prod_hi = PROD_W'(i_value) * PROD_W'(high_recip(i_level));
        quot_lo = prod_lo[RECIP_SHIFT +: YEAR_W];
        quot_hi = prod_hi[RECIP_SHIFT +: YEAR_W];
    end

    // digit is the difference of the two quotients scaled by ten
    always_comb begin
        quot_hi_x10 = YEAR_W'({quot_hi, 3'b000}) + YEAR_W'({quot_hi, 1'b0});
        rem         = quot_lo - quot_hi_x10;
        o_segments  = seg_code(rem[DIGIT_W-1:0], i_common_anode);
    end

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_multiplexer_core.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_multiplexer_core
// Counts millisecond ticks and, once per scan period, emits a scan frame
// with the anode mask and the segment codes for one display column.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick transaction per millisecond with the current date
//   and time; tuser holds the calendar select. The tick counter is updated as
//   each transaction is accepted. When the count reaches the scan period a
//   frame is produced and the scan index advances 0..7, otherwise the tick
//   produces nothing.
//   Path: a frame for a tick passes the input register, then the result
//   register, before it appears on m_axis.
//   Throughput: one tick per cycle while not stalled; the single-pass path is
//   two reciprocal multipliers per digit lane between the two registers.
//   Configuration: i_cfg_we writes the scan period (index 0) or common_anode
//   (index 1); write only while no frame is in flight.
//   Reset: scan index and tick count go to zero, the scan period to 3,
//   common_anode to 1, both channels empty.
//   Stall: when m_axis_tready is low the result register holds its frame, the
//   input register fills, and s_axis_tready drops until the frame is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_scan_multiplexer_core
    import ssm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // tick stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
    // second[39:34], weekday_code[47:40], hijri_code[55:48],
    // colon_enable[56], zero[63:57]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // hijri_select[0]
    input  wire logic                   s_axis_tuser,
    // frame stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // anode_mask[7:0], time_segments[15:8], date_segments[23:16],
    // weekday_byte[31:24], hijri_byte[39:32]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [TICK_W-1:0]   r_scan_period;
    logic                r_common_anode;

    // tick and scan state
    logic [TICK_W-1:0]   r_ticks;
    logic [TICK_W-1:0]   n_ticks;
    logic [SCAN_W-1:0]   r_scan;
    logic                emit;
    logic                in_accept;
    logic                s1_advance;

    // input register
    logic                r_s1_valid;
    logic [SCAN_W-1:0]   r_s1_scan;
    logic [YEAR_W-1:0]   r_s1_year;
    logic [MONTH_W-1:0]  r_s1_month;
    logic [DAY_W-1:0]    r_s1_day;
    logic [HOUR_W-1:0]   r_s1_hour;
    logic [MINUTE_W-1:0] r_s1_minute;
    logic [SECOND_W-1:0] r_s1_second;
    logic [CODE_W-1:0]   r_s1_weekday;
    logic [CODE_W-1:0]   r_s1_hijri;
    logic                r_s1_cal_hijri;
    logic                r_s1_colon;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // frame build signals
    logic [YEAR_W-1:0]   time_value;
    logic [YEAR_W-1:0]   date_value;
    t_level              time_level;
    t_level              date_level;
    logic [SEG_W-1:0]    time_lane_seg;
    logic [SEG_W-1:0]    date_lane_seg;
    logic [SEG_W-1:0]    frame_mask;
    logic [SEG_W-1:0]    frame_tseg;
    logic [SEG_W-1:0]    frame_dseg;
    logic [SEG_W-1:0]    frame_blank;
    logic [CODE_W-1:0]   frame_weekday;
    logic [CODE_W-1:0]   frame_hijri;

    // handshake
    assign s1_advance    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period  <= SCAN_PERIOD_RST;
            r_common_anode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCAN_PERIOD:  r_scan_period  <= i_cfg_data[TICK_W-1:0];
                CFG_COMMON_ANODE: r_common_anode <= i_cfg_data[0];
                default:          r_common_anode <= r_common_anode;
            endcase
        end
    end

    // saturating tick count and step decision
    always_comb begin
        n_ticks = (r_ticks != TICK_MAX) ? TICK_W'(r_ticks + 1'b1) : r_ticks;
        emit    = (n_ticks >= r_scan_period);
    end

    // tick counter and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= '0;
            r_scan  <= '0;
        end else if (in_accept) begin
            if (emit) begin
                r_ticks <= '0;
                r_scan  <= SCAN_W'(r_scan + 1'b1);
            end else begin
                r_ticks <= n_ticks;
            end
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept && emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_s1_scan      <= r_scan;
            r_s1_year      <= s_axis_tdata[13:0];
            r_s1_month     <= s_axis_tdata[17:14];
            r_s1_day       <= s_axis_tdata[22:18];
            r_s1_hour      <= s_axis_tdata[27:23];
            r_s1_minute    <= s_axis_tdata[33:28];
            r_s1_second    <= s_axis_tdata[39:34];
            r_s1_weekday   <= s_axis_tdata[47:40];
            r_s1_hijri     <= s_axis_tdata[55:48];
            r_s1_colon     <= s_axis_tdata[56];
            r_s1_cal_hijri <= s_axis_tuser;
        end
    end

    // digit source for each lane by scan column
    always_comb begin
        time_value = '0;
        date_value = '0;
        time_level = LVL_UNITS;
        date_level = LVL_UNITS;
        unique case (r_s1_scan)
            3'd7: begin
                time_value = r_s1_year;
                time_level = LVL_THOUSANDS;
                date_value = r_s1_year;
                date_level = LVL_HUNDREDS;
            end
            3'd6: begin
                time_value = YEAR_W'(r_s1_hour);
                time_level = LVL_TENS;
                date_value = r_s1_year;
                date_level = LVL_TENS;
            end
            3'd5: begin
                time_value = YEAR_W'(r_s1_hour);
                date_value = r_s1_year;
            end
            3'd4: begin
                time_value = YEAR_W'(r_s1_minute);
                time_level = LVL_TENS;
                date_value = YEAR_W'(r_s1_month);
                date_level = LVL_TENS;
            end
            3'd3: begin
                time_value = YEAR_W'(r_s1_minute);
                date_value = YEAR_W'(r_s1_month);
            end
            3'd2: begin
                time_value = YEAR_W'(r_s1_second);
                time_level = LVL_TENS;
                date_value = YEAR_W'(r_s1_day);
                date_level = LVL_TENS;
            end
            3'd1: begin
                time_value = YEAR_W'(r_s1_second);
                date_value = YEAR_W'(r_s1_day);
            end
            default: begin
                time_value = '0;
                date_value = '0;
            end
        endcase
    end

    ssm_digit_lane u_time_lane (
        .i_value        (time_value),
        .i_level        (time_level),
        .i_common_anode (r_common_anode),
        .o_segments     (time_lane_seg)
    );

    ssm_digit_lane u_date_lane (
        .i_value        (date_value),
        .i_level        (date_level),
        .i_common_anode (r_common_anode),
        .o_segments     (date_lane_seg)
    );

    // frame assembly, column zero blanks the digits and drives the colon
    always_comb begin
        frame_blank   = r_common_anode ? BLANK_ANODE : BLANK_CATH;
        frame_weekday = r_s1_weekday | CODE_W'(r_s1_cal_hijri);
        frame_hijri   = r_s1_hijri | CODE_W'(!r_s1_cal_hijri);
        if (r_s1_scan == '0) begin
            frame_mask = (r_s1_colon && !r_s1_second[0]) ? MASK_COLON : MASK_OFF;
            frame_tseg = frame_blank;
            frame_dseg = frame_blank;
        end else begin
            frame_mask = ~(SEG_W'(1) << (3'd7 - r_s1_scan));
            frame_tseg = time_lane_seg;
            frame_dseg = date_lane_seg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_data <= {frame_hijri, frame_weekday, frame_dseg, frame_tseg, frame_mask};
        end
    end

`ifndef ASSERT_OFF
    // a scan step clears the tick count
    a_step_clears_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && emit) |=> (r_ticks == '0))
        else $error("tick count not cleared after scan step");

    // a scan step advances the column by one
    a_step_advances_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && emit) |=> (r_scan == SCAN_W'($past(r_scan) + 1'b1)))
        else $error("scan index did not advance by one");

    // a tick without a step leaves the column alone
    a_idle_tick_holds_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !emit) |=> $stable(r_scan))
        else $error("scan index moved without a scan step");

    // back-pressure only when both registers hold frames
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_out_valid))
        else $error("tick stream stalled with free pipeline space");
`endif

endmodule

`default_nettype wire

// ===== verif/seven_segment_scan_multiplexer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_scan_multiplexer_core_tb
// Self-checking bench for the scan multiplexer. Tick transactions go in on the
// slave stream and frames come out on the master stream. A model in the bench
// follows the tick counter, the scan position and both registers, and checks
// every frame against it. The run opens with a directed table, then moves
// through a series of random phases under varied register settings, and ends
// with a phase at the longest scan period.
// ----------------------------------------------------------------------------

module seven_segment_scan_multiplexer_core_tb;
    import ssm_pkg::*;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned HOLD_OFF   = 400;

    // one tick transaction, packed from the lowest bit up as on tdata
    typedef struct packed {
        logic                colon;
        logic [CODE_W-1:0]   hijri;
        logic [CODE_W-1:0]   weekday;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } t_tick_data;

    typedef struct packed {
        logic       cal;
        t_tick_data data;
    } t_tick;

    // one frame, anode mask in the lowest byte
    typedef struct packed {
        logic [SEG_W-1:0] hijri;
        logic [SEG_W-1:0] weekday;
        logic [SEG_W-1:0] date_seg;
        logic [SEG_W-1:0] time_seg;
        logic [SEG_W-1:0] anode;
    } t_frame;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
        t_tick                  t;
        bit                     typed;
        t_frame                 want;
    } t_dir_row;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    // model state and register copies
    logic [SCAN_W-1:0]       scan_pos;
    logic [TICK_W-1:0]       tick_count;
    logic [TICK_W-1:0]       scan_interval;
    logic                    anode_mode;

    t_frame                  frames_due [$];
    t_dir_row                rows [$];

    int unsigned             errors        = 0;
    int unsigned             ticks_sent    = 0;
    int unsigned             frames_seen   = 0;
    int unsigned             cfg_writes    = 0;
    int unsigned             burst_left    = 0;
    bit                      steady        = 1'b0;
    logic                    hold_off_req  = 1'b0;
    bit                      hold_off_done = 1'b0;

    seven_segment_scan_multiplexer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // segment code of the units digit of v
    function automatic logic [SEG_W-1:0] digit_code(input int unsigned v);
        case (v % 10)
            0:       return anode_mode ? 8'h88 : 8'h3F;
            1:       return anode_mode ? 8'hBB : 8'h06;
            2:       return anode_mode ? 8'h94 : 8'h5B;
            3:       return anode_mode ? 8'h91 : 8'h4F;
            4:       return anode_mode ? 8'hA3 : 8'h66;
            5:       return anode_mode ? 8'hC1 : 8'h6D;
            6:       return anode_mode ? 8'hC0 : 8'h7D;
            7:       return anode_mode ? 8'h9B : 8'h07;
            8:       return anode_mode ? 8'h80 : 8'h7F;
            default: return anode_mode ? 8'h81 : 8'h6F;
        endcase
    endfunction

    // advance the tick counter; when a scan step is due, build its frame
    function automatic bit compute_frame(input t_tick t, output t_frame f);
        int unsigned yr;
        int unsigned hr;
        int unsigned mi;
        int unsigned se;
        int unsigned mo;
        int unsigned dy;
        yr = t.data.year;
        hr = t.data.hour;
        mi = t.data.minute;
        se = t.data.second;
        mo = t.data.month;
        dy = t.data.day;
        f  = '0;
        if (tick_count != TICK_MAX)
            tick_count = tick_count + 1'b1;
        if (tick_count < scan_interval)
            return 1'b0;
        tick_count = '0;
        f.anode = 8'hFF ^ (8'h80 >> scan_pos);
        case (scan_pos)
            3'd7: begin f.time_seg = digit_code(yr / 1000); f.date_seg = digit_code(yr / 100); end
            3'd6: begin f.time_seg = digit_code(hr / 10);   f.date_seg = digit_code(yr / 10);  end
            3'd5: begin f.time_seg = digit_code(hr);        f.date_seg = digit_code(yr);       end
            3'd4: begin f.time_seg = digit_code(mi / 10);   f.date_seg = digit_code(mo / 10);  end
            3'd3: begin f.time_seg = digit_code(mi);        f.date_seg = digit_code(mo);       end
            3'd2: begin f.time_seg = digit_code(se / 10);   f.date_seg = digit_code(dy / 10);  end
            3'd1: begin f.time_seg = digit_code(se);        f.date_seg = digit_code(dy);       end
            default: begin
                // blank column, colon lit on even seconds
                f.time_seg = anode_mode ? 8'hFF : 8'h00;
                f.date_seg = anode_mode ? 8'hFF : 8'h00;
                f.anode    = (t.data.colon && !t.data.second[0]) ? 8'h7F : 8'hFF;
            end
        endcase
        f.weekday = t.data.weekday | {7'b0, t.cal};
        f.hijri   = t.data.hijri | {7'b0, ~t.cal};
        scan_pos  = scan_pos + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_dir_row tick_row(input int unsigned yr, mo, dy, hr, mi, se, wk, hj,
                                          input bit cal, colon, typed, input t_frame want);
        t_dir_row r;
        r.kind           = ROW_TICK;
        r.cfg_idx        = '0;
        r.cfg_val        = '0;
        r.t.cal          = cal;
        r.t.data.colon   = colon;
        r.t.data.year    = YEAR_W'(yr);
        r.t.data.month   = MONTH_W'(mo);
        r.t.data.day     = DAY_W'(dy);
        r.t.data.hour    = HOUR_W'(hr);
        r.t.data.minute  = MINUTE_W'(mi);
        r.t.data.second  = SECOND_W'(se);
        r.t.data.weekday = CODE_W'(wk);
        r.t.data.hijri   = CODE_W'(hj);
        r.typed          = typed;
        r.want           = want;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r       = tick_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0, '0);
        r.kind    = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // mostly plausible date and time, sometimes any value the widths allow
    function automatic t_tick rand_tick();
        t_tick t;
        t.data.weekday = CODE_W'($urandom);
        t.data.hijri   = CODE_W'($urandom);
        t.data.colon   = 1'($urandom);
        t.cal          = 1'($urandom);
        if ($urandom_range(0, 6) == 0) begin
            t.data.year   = YEAR_W'($urandom);
            t.data.month  = MONTH_W'($urandom);
            t.data.day    = DAY_W'($urandom);
            t.data.hour   = HOUR_W'($urandom);
            t.data.minute = MINUTE_W'($urandom);
            t.data.second = SECOND_W'($urandom);
        end else begin
            t.data.year   = YEAR_W'($urandom_range(0, 9999));
            t.data.month  = MONTH_W'($urandom_range(1, 12));
            t.data.day    = DAY_W'($urandom_range(1, 31));
            t.data.hour   = HOUR_W'($urandom_range(0, 23));
            t.data.minute = MINUTE_W'($urandom_range(0, 59));
            t.data.second = SECOND_W'($urandom_range(0, 59));
        end
        return t;
    endfunction

    // offer one tick, predict on acceptance, then maybe leave a gap
    task automatic send_tick(input t_tick t, input bit typed, input t_frame typed_frame);
        t_frame      f;
        int unsigned gap;
        s_axis_tdata  <= IN_TDATA_W'(t.data);
        s_axis_tuser  <= t.cal;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        ticks_sent++;
        if (compute_frame(t, f))
            frames_due.push_back(typed ? typed_frame : f);
        gap = 0;
        if (!steady) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(0, 40);
            end else begin
                burst_left--;
            end
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every frame is in, plus pipeline slack
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one write cycle, then one idle cycle before the port is driven again
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SCAN_PERIOD)
            scan_interval = val;
        else
            anode_mode = val[0];
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic report(input string what, input t_frame want, input t_frame got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: anode %h/%h time %h/%h date %h/%h wkday %h/%h hijri %h/%h (exp/got)",
                     $realtime, what, want.anode, got.anode, want.time_seg, got.time_seg,
                     want.date_seg, got.date_seg, want.weekday, got.weekday,
                     want.hijri, got.hijri);
    endtask

    // frame checker
    always @(posedge i_clk) begin : frame_check
        t_frame got;
        t_frame want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            frames_seen++;
            if (frames_due.size() == 0) begin
                report("frame with none expected", '0, got);
            end else begin
                want = frames_due.pop_front();
                if (got.anode !== want.anode || got.time_seg !== want.time_seg ||
                    got.date_seg !== want.date_seg || got.weekday !== want.weekday ||
                    got.hijri !== want.hijri)
                    report("frame mismatch", want, got);
            end
        end
    end

    // receiver: stretches of differing stall patterns, one long hold-off on request
    always @(posedge i_clk) begin : rx_pattern
        int unsigned hold_left;
        int unsigned stretch_left;
        int unsigned rx_mode;
        int unsigned rx_phase;
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_OFF;
            m_axis_tready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(10, 120);
                rx_mode      = $urandom_range(0, 3);
            end else begin
                stretch_left--;
            end
            rx_phase++;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_phase % 3 != 0);
            endcase
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin : watchdog
        int unsigned idle;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle = 0;
        end else begin
            idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles with no transaction, %0d frames pending",
                         idle, frames_due.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned phase_interval [10] = '{1, 2, 0, 4, 1, 3, 7, 2, 11, 5};
        bit          phase_anode    [10] = '{1, 0, 1, 0, 0, 1, 0, 1, 1, 0};

        scan_pos      = '0;
        tick_count    = '0;
        scan_interval = SCAN_PERIOD_RST;
        anode_mode    = 1'b1;

        // directed table; typed frames are packed hijri, weekday, date, time, anode
        rows.push_back(tick_row(9999, 12, 31, 23, 59, 59, 8'hFF, 8'hFF, 1, 1, 0, '0));
        rows.push_back(tick_row(0, 1, 1, 0, 0, 0, 8'h00, 8'h00, 0, 0, 0, '0));
        // reset interval of three: third tick opens scan zero with colon lit
        rows.push_back(tick_row(0, 1, 1, 0, 0, 0, 8'h00, 8'h00, 0, 1, 1,
                                40'h01_00_FF_FF_7F));
        rows.push_back(cfg_row(CFG_SCAN_PERIOD, 16'd1));
        rows.push_back(tick_row(2024, 6, 31, 12, 30, 59, 8'h00, 8'hFE, 1, 0, 1,
                                40'hFE_01_BB_81_BF));
        // field extremes beyond the stated ranges
        rows.push_back(tick_row(16383, 15, 31, 31, 63, 63, 8'hAA, 8'h55, 0, 1, 0, '0));
        rows.push_back(tick_row(16383, 15, 31, 31, 63, 63, 8'h55, 8'hAA, 1, 1, 0, '0));
        rows.push_back(tick_row(1234, 10, 19, 23, 47, 36, 8'h01, 8'h01, 0, 0, 0, '0));
        rows.push_back(tick_row(5678, 9, 28, 19, 8, 11, 8'h80, 8'h7F, 1, 0, 0, '0));
        rows.push_back(tick_row(9876, 12, 7, 20, 0, 0, 8'h3C, 8'hC3, 0, 1, 0, '0));
        rows.push_back(tick_row(9999, 12, 31, 23, 59, 59, 8'h5A, 8'h5A, 0, 1, 1,
                                40'h5B_5A_81_81_FE));
        // odd second keeps the colon dark
        rows.push_back(tick_row(2000, 2, 29, 1, 2, 3, 8'h0F, 8'hF0, 1, 1, 0, '0));
        rows.push_back(cfg_row(CFG_COMMON_ANODE, 16'd0));
        rows.push_back(tick_row(0, 1, 1, 0, 0, 0, 8'h00, 8'h00, 0, 0, 1,
                                40'h01_00_06_3F_BF));
        rows.push_back(tick_row(16383, 15, 31, 31, 63, 63, 8'hFF, 8'hFF, 1, 1, 0, '0));
        rows.push_back(tick_row(3456, 11, 15, 14, 45, 50, 8'h12, 8'h34, 0, 0, 0, '0));
        rows.push_back(tick_row(7890, 3, 4, 5, 6, 7, 8'h56, 8'h78, 1, 0, 0, '0));
        rows.push_back(tick_row(1, 12, 30, 9, 59, 9, 8'h9A, 8'hBC, 0, 1, 0, '0));
        rows.push_back(tick_row(16383, 0, 0, 31, 0, 0, 8'hDE, 8'hF0, 1, 1, 0, '0));
        rows.push_back(tick_row(8192, 8, 16, 16, 32, 32, 8'h11, 8'h22, 0, 0, 0, '0));
        rows.push_back(tick_row(0, 1, 1, 0, 0, 2, 8'h80, 8'h80, 1, 1, 1,
                                40'h80_81_00_00_7F));
        rows.push_back(tick_row(4321, 7, 17, 17, 17, 18, 8'h44, 8'h88, 0, 0, 0, '0));
        // an interval of zero steps on every tick
        rows.push_back(cfg_row(CFG_SCAN_PERIOD, 16'd0));
        rows.push_back(tick_row(9090, 10, 20, 10, 40, 40, 8'hE7, 8'h18, 1, 1, 0, '0));
        rows.push_back(tick_row(101, 1, 10, 22, 33, 44, 8'h7E, 8'h81, 0, 1, 0, '0));
        rows.push_back(tick_row(16000, 14, 30, 30, 62, 62, 8'hC0, 8'h03, 1, 0, 0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                settle();
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            end else begin
                send_tick(rows[i].t, rows[i].typed, rows[i].want);
            end
        end

        // random phases under a spread of register settings
        for (int p = 0; p < 10; p++) begin
            settle();
            write_reg(CFG_SCAN_PERIOD, CFG_DATA_W'(phase_interval[p]));
            write_reg(CFG_COMMON_ANODE, CFG_DATA_W'(phase_anode[p]));
            // one frame per tick here, so a long receiver stall backs up the input
            if (p == 4)
                hold_off_req <= 1'b1;
            for (int n = 0; n < 100; n++) begin
                // sender waits out every pending frame once mid-phase
                if (p == 6 && n == 55)
                    settle();
                send_tick(rand_tick(), 1'b0, '0);
            end
        end

        // widest scan period: the count stays short of it for the whole stretch
        settle();
        write_reg(CFG_SCAN_PERIOD, 16'hFFFF);
        write_reg(CFG_COMMON_ANODE, 16'd1);
        steady = 1'b1;
        for (int n = 0; n < 80; n++)
            send_tick(rand_tick(), 1'b0, '0);
        steady = 1'b0;

        settle();
        repeat (8) @(posedge i_clk);
        if (frames_due.size() != 0) begin
            errors++;
            $display("%0d expected frames never arrived", frames_due.size());
        end
        $display("run covered %0d ticks and %0d frames over %0d register writes",
                 ticks_sent, frames_seen, cfg_writes);
        $display("intervals 0 through 65535, both segment polarities, long output stall %0s",
                 hold_off_done ? "applied" : "missed");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
